// File: design/fwp_pkg.sv
// ----------------------------------------------------------------------------
// fwp_pkg
// Shared types and constants of the framed register write parser.
// ----------------------------------------------------------------------------
package fwp_pkg;

    localparam int BYTE_W     = 8;
    localparam int GRP_W      = 7;   // up to 63 groups of four bytes
    localparam int WADDR_W    = 10;
    localparam int WVAL_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int M_TDATA_W  = 32;

    localparam logic [BYTE_W-1:0] HDR_FIRST_RST  = 8'hFF;
    localparam logic [BYTE_W-1:0] HDR_SECOND_RST = 8'hFA;

    // configuration register indexes
    localparam logic CFG_HEADER_FIRST  = 1'b0;
    localparam logic CFG_HEADER_SECOND = 1'b1;

    // result kinds
    localparam logic [STATUS_W-1:0] ST_WRITE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CSUM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_FETCH = 2'd1,
        BK_OUT   = 2'd2
    } t_back_state;

    typedef struct packed {
        logic             is_err;
        logic [GRP_W-1:0] groups;
    } t_job;

endpackage

// File: design/fwp_store.sv
// ----------------------------------------------------------------------------
// fwp_store
// Payload byte memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fwp_store
    import fwp_pkg::*;
#(
    parameter int FRAME_BUFFER_DEPTH = 256,
    localparam int AW = $clog2(FRAME_BUFFER_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [FRAME_BUFFER_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/fwp_job_fifo.sv
// ----------------------------------------------------------------------------
// fwp_job_fifo
// Two-entry queue of frame jobs between the parser and the write sequencer.
// ----------------------------------------------------------------------------
module fwp_job_fifo
    import fwp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    logic       push_ok;
    logic       pop_ok;

    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wp  = push_ok ? !r_wp : r_wp;
        n_rp  = pop_ok ? !r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

// File: design/fwp_front.sv
// ----------------------------------------------------------------------------
// fwp_front
// Byte parser: header hunt, length, payload store and checksum, job issue.
// ----------------------------------------------------------------------------
module fwp_front
    import fwp_pkg::*;
#(
    parameter int FRAME_BUFFER_DEPTH = 256,
    localparam int AW = $clog2(FRAME_BUFFER_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_index,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_q_full,
    input  logic              i_mem_busy,
    output logic              o_push,
    output t_job              o_job,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [BYTE_W-1:0] o_wr_data
);

    t_phase            r_phase;
    t_phase            n_phase;
    logic [BYTE_W-1:0] r_len;
    logic [BYTE_W-1:0] n_len;
    logic [BYTE_W-1:0] r_bt;
    logic [BYTE_W-1:0] n_bt;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] n_sum;
    logic [BYTE_W-1:0] r_hdr1;
    logic [BYTE_W-1:0] r_hdr2;

    logic              accept;
    logic [BYTE_W-1:0] bt_inc;
    logic [BYTE_W:0]   plen;
    logic [BYTE_W:0]   held;
    logic [GRP_W-1:0]  groups;

    // payload must wait while the sequencer still reads the previous frame
    assign o_s_tready = !i_q_full && !((r_phase == PH_PAYLOAD) && i_mem_busy);
    assign accept     = i_s_tvalid && o_s_tready;
    assign bt_inc     = r_bt + 8'd1;

    // groups that lie wholly inside the store
    assign plen   = {1'b0, r_len} - 9'd1;
    assign held   = (plen > 9'(FRAME_BUFFER_DEPTH)) ? 9'(FRAME_BUFFER_DEPTH) : plen;
    assign groups = held[BYTE_W:2];

    // next state
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_bt    = r_bt;
        n_sum   = r_sum;
        if (accept) begin
            unique case (r_phase)
                PH_HUNT2: begin
                    if (i_s_tdata == r_hdr2) begin
                        n_phase = PH_LEN;
                    end else if (i_s_tdata == r_hdr1) begin
                        n_phase = PH_HUNT2;
                    end else begin
                        n_phase = PH_HUNT1;
                    end
                end
                PH_LEN: begin
                    n_len = i_s_tdata;
                    n_bt  = '0;
                    n_sum = '0;
                    if (i_s_tdata == 8'd0) begin
                        n_phase = PH_HUNT1;
                    end else if (i_s_tdata == 8'd1) begin
                        n_phase = PH_CHECK;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_sum = r_sum + i_s_tdata;
                    n_bt  = bt_inc;
                    if (({1'b0, bt_inc} + 9'd1) >= {1'b0, r_len}) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_phase = PH_HUNT1;
                end
                default: begin
                    n_phase = (i_s_tdata == r_hdr1) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_wr_en       = accept && (r_phase == PH_PAYLOAD)
                        && ({1'b0, r_bt} < 9'(FRAME_BUFFER_DEPTH));
        o_wr_addr     = r_bt[AW-1:0];
        o_wr_data     = i_s_tdata;
        o_job.is_err  = (i_s_tdata != r_sum);
        o_job.groups  = groups;
        o_push        = accept && (r_phase == PH_CHECK)
                        && ((i_s_tdata != r_sum) || (groups != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_len   <= '0;
            r_bt    <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_bt    <= n_bt;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr1 <= HDR_FIRST_RST;
            r_hdr2 <= HDR_SECOND_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEADER_FIRST:  r_hdr1 <= i_cfg_data;
                CFG_HEADER_SECOND: r_hdr2 <= i_cfg_data;
                default:           r_hdr1 <= r_hdr1;
            endcase
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("job issued into a full queue");

    a_store_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> !i_mem_busy)
        else $error("payload written while sequencer reads the store");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_phase == PH_LEN) && (i_s_tdata == 8'd0)) |=> (r_phase == PH_HUNT1))
        else $error("zero length frame not dropped");

endmodule

// File: design/fwp_back.sv
// ----------------------------------------------------------------------------
// fwp_back
// Write sequencer: reads payload groups from the store and emits results.
// ----------------------------------------------------------------------------
module fwp_back
    import fwp_pkg::*;
#(
    parameter int FRAME_BUFFER_DEPTH = 256,
    parameter int REGISTER_COUNT     = 1024,
    localparam int AW = $clog2(FRAME_BUFFER_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  t_job                i_job,
    output logic                o_pop,
    output logic                o_busy,
    output logic [AW-1:0]       o_rd_addr,
    input  logic [BYTE_W-1:0]   i_rd_data,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [WADDR_W-1:0]  o_addr,
    output logic [WVAL_W-1:0]   o_val,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_last
);

    t_back_state r_state;
    t_back_state n_state;

    logic [GRP_W-1:0]    r_grp;
    logic [GRP_W-1:0]    n_grp;
    logic [GRP_W-1:0]    r_ngrp;
    logic [GRP_W-1:0]    n_ngrp;
    logic [2:0]          r_cnt;
    logic [2:0]          n_cnt;
    logic [23:0]         r_acc;
    logic [23:0]         n_acc;
    logic [WADDR_W-1:0]  r_addr;
    logic [WADDR_W-1:0]  n_addr;
    logic [WVAL_W-1:0]   r_val;
    logic [WVAL_W-1:0]   n_val;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic                r_last;
    logic                n_last;

    logic [31:0]         word;
    logic [GRP_W+1:0]    rd_byte;
    logic                out_acc;
    logic                out_range;

    assign word      = {r_acc, i_rd_data};
    assign rd_byte   = {r_grp, r_cnt[1:0]};
    assign out_acc   = o_m_tvalid && i_m_tready;
    assign out_range = {1'b0, word[31:16]} >= 17'(REGISTER_COUNT);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_job.is_err ? BK_OUT : BK_FETCH;
                end
            end
            BK_FETCH: begin
                if (r_cnt == 3'd4) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (out_acc) begin
                    n_state = r_last ? BK_IDLE : BK_FETCH;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop      = (r_state == BK_IDLE) && !i_q_empty;
        o_busy     = (r_state != BK_IDLE);
        o_m_tvalid = (r_state == BK_OUT);
        o_rd_addr  = rd_byte[AW-1:0];
        o_addr     = r_addr;
        o_val      = r_val;
        o_status   = r_status;
        o_last     = r_last;
    end

    // datapath
    always_comb begin
        n_grp    = r_grp;
        n_ngrp   = r_ngrp;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_addr   = r_addr;
        n_val    = r_val;
        n_status = r_status;
        n_last   = r_last;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    n_ngrp = i_job.groups;
                    n_grp  = '0;
                    n_cnt  = '0;
                    if (i_job.is_err) begin
                        n_addr   = '0;
                        n_val    = '0;
                        n_status = ST_CSUM;
                        n_last   = 1'b1;
                    end
                end
            end
            BK_FETCH: begin
                // read issued at count k returns at count k+1
                if (r_cnt != 3'd0) begin
                    n_acc = {r_acc[15:0], i_rd_data};
                end
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    if (out_range) begin
                        n_addr   = '0;
                        n_val    = '0;
                        n_status = ST_RANGE;
                        n_last   = 1'b1;
                    end else begin
                        n_addr   = word[16+WADDR_W-1:16];
                        n_val    = word[WVAL_W-1:0];
                        n_status = ST_WRITE;
                        n_last   = ((r_grp + 7'd1) == r_ngrp);
                    end
                end
            end
            BK_OUT: begin
                if (out_acc && !r_last) begin
                    n_grp = r_grp + 7'd1;
                    n_cnt = '0;
                end
            end
            default: n_cnt = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp    <= n_grp;
        r_ngrp   <= n_ngrp;
        r_cnt    <= n_cnt;
        r_acc    <= n_acc;
        r_addr   <= n_addr;
        r_val    <= n_val;
        r_status <= n_status;
        r_last   <= n_last;
    end

    a_csum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_status == ST_CSUM)) |-> o_last)
        else $error("checksum error not marked as last");

    a_range_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_status == ST_RANGE)) |-> (o_last && (o_addr == '0)))
        else $error("range error must end the frame with zero address");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last) |=> (r_state == BK_IDLE))
        else $error("sequencer did not return to idle after last result");

endmodule

// File: design/framed_register_write_parser_top.sv
// ----------------------------------------------------------------------------
// framed_register_write_parser_top
// Serial frame parser with additive checksum that issues register writes.
// ----------------------------------------------------------------------------
// results: a checksum error is issued straight from the job queue; each
//   register write waits for the four single-byte reads of the payload store
//   that make up its group
// throughput: one byte per cycle on the input while the job queue has room;
//   payload bytes of a new frame wait while the write sequencer still reads the previous frame
// reset: synchronous active low; header bytes return to 0xFF and 0xFA and the
//   parser hunts for a header; the payload store is not cleared
// ----------------------------------------------------------------------------
module framed_register_write_parser_top
    import fwp_pkg::*;
#(
    parameter int FRAME_BUFFER_DEPTH = 256,
    parameter int REGISTER_COUNT     = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [BYTE_W-1:0]    i_s_tdata,   // [7:0] rx_byte
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // [9:0] write_address, [25:10] write_value
    output logic [STATUS_W-1:0]  o_m_tuser,   // [1:0] frame_status
    output logic                 o_m_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(FRAME_BUFFER_DEPTH);

    t_job                q_in;
    t_job                q_out;
    logic                q_push;
    logic                q_pop;
    logic                q_empty;
    logic                q_full;
    logic                back_busy;
    logic                mem_busy;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [BYTE_W-1:0]   wr_data;
    logic [AW-1:0]       rd_addr;
    logic [BYTE_W-1:0]   rd_data;
    logic [WADDR_W-1:0]  res_addr;
    logic [WVAL_W-1:0]   res_val;

    assign o_cfg_ready = 1'b1;
    assign mem_busy    = back_busy || !q_empty;

    fwp_front #(
        .FRAME_BUFFER_DEPTH (FRAME_BUFFER_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .i_mem_busy  (mem_busy),
        .o_push      (q_push),
        .o_job       (q_in),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    fwp_store #(
        .FRAME_BUFFER_DEPTH (FRAME_BUFFER_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    fwp_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    fwp_back #(
        .FRAME_BUFFER_DEPTH (FRAME_BUFFER_DEPTH),
        .REGISTER_COUNT     (REGISTER_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_job      (q_out),
        .o_pop      (q_pop),
        .o_busy     (back_busy),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_addr     (res_addr),
        .o_val      (res_val),
        .o_status   (o_m_tuser),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {6'd0, res_val, res_addr};

endmodule

// File: tb/framed_register_write_parser_top_tb.sv
// ----------------------------------------------------------------------------
// framed_register_write_parser_top_tb
// Drives byte streams of framed register writes into the parser: directed
// frames for the corner cases, then mostly well-formed random frames mixed
// with noise, dropped and truncated frames, under several header settings.
// Every result is checked field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
module framed_register_write_parser_top_tb
    import fwp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_DEPTH    = 256;
    localparam int REG_COUNT    = 1024;
    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT  = 2000;

    typedef logic [BYTE_W-1:0] t_byte_q[$];

    typedef struct {
        logic [WADDR_W-1:0]  addr;
        logic [WVAL_W-1:0]   val;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_wr_result;

    class register_write_scoreboard;
        logic [BYTE_W-1:0] hdr_first;
        logic [BYTE_W-1:0] hdr_second;
        t_phase            phase;
        logic [BYTE_W-1:0] frm_len;
        logic [BYTE_W-1:0] taken;
        logic [BYTE_W-1:0] csum;
        logic [BYTE_W-1:0] store [BUF_DEPTH];
        t_wr_result        expected_writes[$];
        int                errors;

        function new();
            hdr_first  = HDR_FIRST_RST;
            hdr_second = HDR_SECOND_RST;
            phase      = PH_HUNT1;
            frm_len    = '0;
            taken      = '0;
            csum       = '0;
            errors     = 0;
        endfunction

        function void set_header(logic idx, logic [BYTE_W-1:0] v);
            case (idx)
                CFG_HEADER_FIRST:  hdr_first  = v;
                CFG_HEADER_SECOND: hdr_second = v;
            endcase
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        // walk the stored groups of a frame whose checksum matched
        function void queue_writes();
            t_wr_result r;
            int         held;
            int         groups;
            logic [15:0] a16;
            held = int'(frm_len) - 1;
            if (held > BUF_DEPTH) held = BUF_DEPTH;
            groups = held / 4;
            for (int g = 0; g < groups; g++) begin
                a16 = {store[4*g], store[4*g+1]};
                if (a16 >= REG_COUNT) begin
                    r.addr   = '0;
                    r.val    = '0;
                    r.status = ST_RANGE;
                    r.last   = 1'b1;
                    expected_writes.push_back(r);
                    return;
                end
                r.addr   = a16[WADDR_W-1:0];
                r.val    = {store[4*g+2], store[4*g+3]};
                r.status = ST_WRITE;
                r.last   = (g + 1 == groups);
                expected_writes.push_back(r);
            end
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            t_wr_result r;
            case (phase)
                PH_HUNT2: begin
                    if (b == hdr_second) phase = PH_LEN;
                    else if (b == hdr_first) phase = PH_HUNT2;
                    else phase = PH_HUNT1;
                end
                PH_LEN: begin
                    frm_len = b;
                    taken   = '0;
                    csum    = '0;
                    if (b == 8'd0) phase = PH_HUNT1;
                    else if (b == 8'd1) phase = PH_CHECK;
                    else phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (int'(taken) < BUF_DEPTH) store[taken] = b;
                    csum  = csum + b;
                    taken = taken + 8'd1;
                    if (int'(taken) + 1 >= int'(frm_len)) phase = PH_CHECK;
                end
                PH_CHECK: begin
                    if (b != csum) begin
                        r.addr   = '0;
                        r.val    = '0;
                        r.status = ST_CSUM;
                        r.last   = 1'b1;
                        expected_writes.push_back(r);
                    end else begin
                        queue_writes();
                    end
                    phase = PH_HUNT1;
                end
                default: begin
                    phase = (b == hdr_first) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        endfunction

        function void check_result(logic [WADDR_W-1:0] addr, logic [WVAL_W-1:0] val,
                                   logic [STATUS_W-1:0] status, logic last);
            t_wr_result e;
            if (expected_writes.size() == 0) begin
                $error("unexpected result: address %0d value 0x%04h status %0d last %0b",
                       addr, val, status, last);
                errors++;
                return;
            end
            e = expected_writes.pop_front();
            if (addr !== e.addr) begin
                $error("write_address: expected %0d, got %0d", e.addr, addr);
                errors++;
            end
            if (val !== e.val) begin
                $error("write_value: expected 0x%04h, got 0x%04h", e.val, val);
                errors++;
            end
            if (status !== e.status) begin
                $error("frame_status: expected %0d, got %0d", e.status, status);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_of_frame: expected %0b, got %0b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [BYTE_W-1:0]    i_s_tdata   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [STATUS_W-1:0]  o_m_tuser;
    logic                 o_m_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_index = CFG_HEADER_FIRST;
    logic [BYTE_W-1:0]    i_cfg_data  = '0;

    register_write_scoreboard sb = new();

    bit gaps_on     = 1'b0;
    bit stalls_on   = 1'b0;
    int stall_left  = 0;
    int bytes_sent  = 0;
    int quiet_cycles = 0;

    framed_register_write_parser_top #(
        .FRAME_BUFFER_DEPTH (BUF_DEPTH),
        .REGISTER_COUNT     (REG_COUNT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check accepted writes, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata[WADDR_W-1:0], o_m_tdata[WADDR_W+WVAL_W-1:WADDR_W],
                            o_m_tuser, o_m_tlast);
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_results_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic send_frame(input t_byte_q body, input bit bad_sum);
        logic [BYTE_W-1:0] sum;
        sum = '0;
        foreach (body[i]) sum = sum + body[i];
        send_byte(sb.hdr_first);
        send_byte(sb.hdr_second);
        send_byte(8'(body.size() + 1));
        foreach (body[i]) send_byte(body[i]);
        send_byte(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
    endtask

    // address high bytes stay below the register count unless oor_pct hits
    function automatic t_byte_q random_body(input int n_bytes, input int oor_pct);
        t_byte_q q;
        for (int i = 0; i < n_bytes; i++) begin
            if (i % 4 == 0) begin
                if ($urandom_range(0, 99) < oor_pct) q.push_back(8'($urandom_range(4, 255)));
                else q.push_back(8'($urandom_range(0, 3)));
            end else begin
                q.push_back(8'($urandom));
            end
        end
        return q;
    endfunction

    task automatic write_headers(input logic [BYTE_W-1:0] first_b,
                                 input logic [BYTE_W-1:0] second_b);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_HEADER_FIRST;
        i_cfg_data  <= first_b;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_header(CFG_HEADER_FIRST, first_b);
        i_cfg_index <= CFG_HEADER_SECOND;
        i_cfg_data  <= second_b;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_header(CFG_HEADER_SECOND, second_b);
        i_cfg_valid <= 1'b0;
    endtask

    // bring the parser back to hunting, let it go quiet, then retune headers
    task automatic retune(input logic [BYTE_W-1:0] first_b, input logic [BYTE_W-1:0] second_b);
        logic [BYTE_W-1:0] filler;
        filler = '0;
        while (filler == sb.hdr_first || filler == sb.hdr_second) filler++;
        while (sb.phase != PH_HUNT1) begin
            if (sb.phase == PH_HUNT2) send_byte(filler);
            else send_byte(8'd0);
        end
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_headers(first_b, second_b);
    endtask

    task automatic random_traffic(input int budget, input bit idle_allowed);
        int      pick;
        int      len;
        t_byte_q body;
        bytes_sent = 0;
        while (bytes_sent < budget) begin
            gaps_on   = idle_allowed && ($urandom_range(0, 3) != 0);
            stalls_on = idle_allowed && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else if (pick < 12) begin
                send_byte(sb.hdr_first);
                send_byte(sb.hdr_second);
                send_byte(8'd0);
            end else if (pick < 17) begin
                // truncated frame, the next bytes land in its payload
                len = $urandom_range(6, 40);
                send_byte(sb.hdr_first);
                send_byte(sb.hdr_second);
                send_byte(8'(len));
                body = random_body($urandom_range(0, len - 2), 6);
                foreach (body[i]) send_byte(body[i]);
            end else begin
                if ($urandom_range(0, 9) == 0 && sb.hdr_first != sb.hdr_second)
                    send_byte(sb.hdr_first);
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 21)
                                                   : $urandom_range(22, 80);
                send_frame(random_body(len - 1, 6), $urandom_range(0, 7) == 0);
            end
            if ($urandom_range(0, 14) == 0) wait_results_drained();
        end
    endtask

    initial begin
        t_byte_q pl;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default headers: noise, max address with partial group, write then
        // out of range, repeated first header with length one, length zero,
        // checksum error on length one
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_byte(8'h00);
        pl = {8'h03, 8'hFF, 8'h00, 8'h00, 8'hA5};
        send_frame(pl, 1'b0);
        pl = {8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
        send_frame(pl, 1'b0);
        send_byte(sb.hdr_first);
        pl.delete();
        send_frame(pl, 1'b0);
        send_byte(sb.hdr_first);
        send_byte(sb.hdr_second);
        send_byte(8'd0);
        pl.delete();
        send_frame(pl, 1'b1);
        wait_results_drained();

        random_traffic(15, 1'b1);
        retune(8'h00, 8'hFF);
        random_traffic(15, 1'b1);
        retune(8'h5A, 8'h5A);
        random_traffic(15, 1'b1);
        retune(8'hFF, 8'h00);
        random_traffic(15, 1'b1);
        retune(8'($urandom), 8'($urandom));

        // no idling from here on; longest frame first
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_frame(random_body(254, 0), 1'b0);
        random_traffic(10, 1'b0);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
